FILE: sv/gwt_pkg.sv
// ----------------------------------------------------------------------------
// gwt_pkg
// Shared types and constants of the G-code word tokenizer: character codes,
// the word record, the open-word kind and the letter-to-mask-bit table.
// ----------------------------------------------------------------------------
package gwt_pkg;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_POINT   = 8'h2E;

	localparam int LETTER_COUNT = 26;
	localparam logic [4:0] LAST_LETTER = 5'd25;

	// output queue between the tokenizer stage and the word channel
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_UPPER = 2'd1,
		KIND_LOWER = 2'd2
	} kind_t;

	typedef struct packed {
		logic [4:0]               letter_index;
		logic signed [31:0]       word_value;
		logic [LETTER_COUNT-1:0]  letters_seen;
		logic                     value_saturated;
		logic                     end_of_command;
	} word_t;

	// fixed letter-to-bit assignment of the seen mask
	function automatic logic [LETTER_COUNT-1:0] letter_bit(input logic [4:0] idx);
		logic [LETTER_COUNT-1:0] m;
		m = '0;
		case (idx)
			5'd0:    m[9]  = 1'b1;
			5'd1:    m[10] = 1'b1;
			5'd2:    m[11] = 1'b1;
			5'd3:    m[12] = 1'b1;
			5'd4:    m[13] = 1'b1;
			5'd5:    m[14] = 1'b1;
			5'd6:    m[0]  = 1'b1;
			5'd7:    m[15] = 1'b1;
			5'd8:    m[16] = 1'b1;
			5'd9:    m[17] = 1'b1;
			5'd10:   m[18] = 1'b1;
			5'd11:   m[19] = 1'b1;
			5'd12:   m[1]  = 1'b1;
			5'd13:   m[2]  = 1'b1;
			5'd14:   m[20] = 1'b1;
			5'd15:   m[7]  = 1'b1;
			5'd16:   m[21] = 1'b1;
			5'd17:   m[22] = 1'b1;
			5'd18:   m[6]  = 1'b1;
			5'd19:   m[8]  = 1'b1;
			5'd20:   m[23] = 1'b1;
			5'd21:   m[24] = 1'b1;
			5'd22:   m[25] = 1'b1;
			5'd23:   m[3]  = 1'b1;
			5'd24:   m[4]  = 1'b1;
			5'd25:   m[5]  = 1'b1;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

FILE: sv/gwt_if.sv
// ----------------------------------------------------------------------------
// gwt_if
// Valid/ready channels of the tokenizer: command bytes in, words out.
// ----------------------------------------------------------------------------
interface gwt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_line;

	modport source (output valid, output char_byte, output end_of_line, input ready);
	modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface

interface gwt_word_if;
	logic               valid;
	logic               ready;
	logic [4:0]         letter_index;
	logic signed [31:0] word_value;
	logic [25:0]        letters_seen;
	logic               value_saturated;
	logic               end_of_command;

	modport source (output valid, output letter_index, output word_value,
		output letters_seen, output value_saturated, output end_of_command, input ready);
	modport sink   (input valid, input letter_index, input word_value,
		input letters_seen, input value_saturated, input end_of_command, output ready);
endinterface

FILE: sv/gcode_word_tokenizer_top.sv
// ----------------------------------------------------------------------------
// gcode_word_tokenizer_top
// Splits a command line, one byte per request, into letter/number words.
// ----------------------------------------------------------------------------
// Usage:
//   chars : one ASCII byte per request, end_of_line high on the last byte.
//   words : one word per request: letter, signed value, letters-seen mask,
//           saturation flag, end_of_command on the word closed by end of line.
//   A byte is registered on acceptance in the input stage and tokenized there,
//   which pushes zero, one or two words into a four-entry output queue. A
//   word passes the input stage register and the queue on its way to words.
//   Throughput is one byte per cycle while the queue has room; the limit is the
//   single tokenizer stage with its multiply-by-ten accumulate and the
//   one-word-per-cycle drain of the output queue. An uppercase letter byte
//   ending the line after an open uppercase word yields two words.
//   When the receiver stalls, the queue fills; the tokenizer stage holds its
//   byte while more than two words wait, and chars.ready then drops.
//   Reset clears the open word, the number, the letters-seen mask, the input
//   stage and the queue; no word is pending afterwards.
// ----------------------------------------------------------------------------
module gcode_word_tokenizer_top
	import gwt_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	gwt_char_if.sink       chars,
	gwt_word_if.source     words
);

	localparam int WIDE_BITS = (VALUE_BITS > 32) ? VALUE_BITS : 32;
	localparam int PROD_BITS = VALUE_BITS + 4;
	localparam logic [PROD_BITS-1:0]  CAP_P  = PROD_BITS'(1) << (VALUE_BITS - 1);
	localparam logic [VALUE_BITS-1:0] CAP    = VALUE_BITS'(1) << (VALUE_BITS - 1);
	localparam logic [VALUE_BITS-1:0] CAP_M1 = CAP - VALUE_BITS'(1);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eol_s1;

	// line state
	logic [4:0]              letter_q;
	kind_t                   kind_q;
	logic [VALUE_BITS-1:0]   acc_q;
	logic                    neg_q;
	logic                    point_q;
	logic                    ovf_q;
	logic [LETTER_COUNT-1:0] mask_q;

	// output queue
	word_t                 queue_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QCNT_BITS-1:0]  count_q;

	logic                    go;
	logic                    pop;
	logic [4:0]              letter_n;
	kind_t                   kind_n;
	logic [VALUE_BITS-1:0]   acc_n;
	logic                    neg_n;
	logic                    point_n;
	logic                    ovf_n;
	logic [PROD_BITS-1:0]    prod;
	logic                    emit_a;
	logic                    emit_b;
	logic [LETTER_COUNT-1:0] mask_a;
	logic [LETTER_COUNT-1:0] mask_mid;
	logic [LETTER_COUNT-1:0] mask_b;
	logic [WIDE_BITS:0]      val_a;
	logic [WIDE_BITS:0]      val_b;
	word_t                   word_a;
	word_t                   word_b;
	word_t                   word_first;
	logic [1:0]              push_n;

	// {saturated, value} of a word from its magnitude and flags
	function automatic logic [WIDE_BITS:0] make_value(
		input logic [VALUE_BITS-1:0] mag,
		input logic                  neg,
		input logic                  ovf
	);
		logic [WIDE_BITS-1:0] mag_w;
		logic [WIDE_BITS-1:0] val;
		logic                 sat;
		mag_w = WIDE_BITS'(mag);
		sat   = ovf;
		if (neg) begin
			val = '0 - mag_w;
		end else if (mag > CAP_M1) begin
			val = WIDE_BITS'(CAP_M1);
			sat = 1'b1;
		end else begin
			val = mag_w;
		end
		return {sat, val};
	endfunction

	assign go           = valid_s1 && (count_q <= QCNT_BITS'(QUEUE_DEPTH - 2));
	assign chars.ready  = !valid_s1 || go;
	assign pop          = words.valid && words.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			byte_s1 <= chars.char_byte;
			eol_s1  <= chars.end_of_line;
		end
	end

	always_comb begin
		letter_n = letter_q;
		kind_n   = kind_q;
		acc_n    = acc_q;
		neg_n    = neg_q;
		point_n  = point_q;
		ovf_n    = ovf_q;
		emit_a   = 1'b0;
		prod     = (PROD_BITS'(acc_q) << 3) + (PROD_BITS'(acc_q) << 1)
			+ PROD_BITS'(byte_s1[3:0]);
		if (byte_s1 inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			emit_a   = (kind_q == KIND_UPPER);
			letter_n = 5'(byte_s1 - CH_UPPER_A);
			kind_n   = KIND_UPPER;
			acc_n    = '0;
			neg_n    = 1'b0;
			point_n  = 1'b0;
			ovf_n    = 1'b0;
		end else if (byte_s1 inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
			emit_a   = (kind_q == KIND_UPPER);
			letter_n = 5'(byte_s1 - CH_LOWER_A);
			kind_n   = KIND_LOWER;
			acc_n    = '0;
			neg_n    = 1'b0;
			point_n  = 1'b0;
			ovf_n    = 1'b0;
		end else if (byte_s1 inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
			if (kind_q != KIND_NONE && !point_q) begin
				// clamp once the magnitude would pass 2^(VALUE_BITS-1)
				if (prod > CAP_P) begin
					acc_n = CAP;
					ovf_n = 1'b1;
				end else begin
					acc_n = prod[VALUE_BITS-1:0];
				end
			end
		end else if (byte_s1 == CH_MINUS) begin
			if (acc_q == '0 && !point_q && !ovf_q) begin
				neg_n = 1'b1;
			end
		end else if (byte_s1 == CH_POINT) begin
			point_n = 1'b1;
		end

		emit_b   = eol_s1 && (kind_n == KIND_UPPER);
		mask_a   = mask_q | letter_bit(letter_q);
		mask_mid = emit_a ? mask_a : mask_q;
		mask_b   = mask_mid | letter_bit(letter_n);

		val_a = make_value(acc_q, neg_q, ovf_q);
		val_b = make_value(acc_n, neg_n, ovf_n);

		word_a.letter_index    = letter_q;
		word_a.word_value      = signed'(val_a[31:0]);
		word_a.letters_seen    = mask_a;
		word_a.value_saturated = val_a[WIDE_BITS];
		word_a.end_of_command  = 1'b0;

		word_b.letter_index    = letter_n;
		word_b.word_value      = signed'(val_b[31:0]);
		word_b.letters_seen    = mask_b;
		word_b.value_saturated = val_b[WIDE_BITS];
		word_b.end_of_command  = 1'b1;

		word_first = emit_a ? word_a : word_b;
		push_n     = go ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			letter_q <= '0;
			kind_q   <= KIND_NONE;
			acc_q    <= '0;
			neg_q    <= 1'b0;
			point_q  <= 1'b0;
			ovf_q    <= 1'b0;
			mask_q   <= '0;
		end else if (go) begin
			if (eol_s1) begin
				// drop everything at the end of the line
				letter_q <= '0;
				kind_q   <= KIND_NONE;
				acc_q    <= '0;
				neg_q    <= 1'b0;
				point_q  <= 1'b0;
				ovf_q    <= 1'b0;
				mask_q   <= '0;
			end else begin
				letter_q <= letter_n;
				kind_q   <= kind_n;
				acc_q    <= acc_n;
				neg_q    <= neg_n;
				point_q  <= point_n;
				ovf_q    <= ovf_n;
				mask_q   <= mask_mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= word_first;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + QPTR_BITS'(1)] <= word_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_q + QPTR_BITS'(pop);
			wr_ptr_q <= wr_ptr_q + QPTR_BITS'(push_n);
			count_q  <= count_q + QCNT_BITS'(push_n) - QCNT_BITS'(pop);
		end
	end

	assign words.valid           = (count_q != '0);
	assign words.letter_index    = queue_q[rd_ptr_q].letter_index;
	assign words.word_value      = queue_q[rd_ptr_q].word_value;
	assign words.letters_seen    = queue_q[rd_ptr_q].letters_seen;
	assign words.value_saturated = queue_q[rd_ptr_q].value_saturated;
	assign words.end_of_command  = queue_q[rd_ptr_q].end_of_command;

endmodule

FILE: sv/gwt_checker.sv
// ----------------------------------------------------------------------------
// gwt_checker
// Port-level checks of the tokenizer's word channel, bound to the top level.
// ----------------------------------------------------------------------------
module gwt_checker
	import gwt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [4:0]  letter_index,
	input logic [31:0] word_value,
	input logic [25:0] letters_seen,
	input logic        value_saturated,
	input logic        end_of_command
);

	logic first_q;

	// track whether the next word opens a new line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			first_q <= end_of_command;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(letter_index)
			&& $stable(word_value) && $stable(letters_seen)
			&& $stable(value_saturated) && $stable(end_of_command))
		else $error("word changed while stalled");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> letter_index <= LAST_LETTER)
		else $error("letter index out of range");

	a_own_letter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (letters_seen & letter_bit(letter_index)) != '0)
		else $error("mask misses the word's own letter");

	a_line_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_q |-> $onehot(letters_seen))
		else $error("mask not cleared at start of line");

endmodule

bind gcode_word_tokenizer_top gwt_checker u_gwt_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (words.valid),
	.out_ready       (words.ready),
	.letter_index    (words.letter_index),
	.word_value      (words.word_value),
	.letters_seen    (words.letters_seen),
	.value_saturated (words.value_saturated),
	.end_of_command  (words.end_of_command)
);
